FILE: rtl/fte_pkg.sv
package fte_pkg;

  localparam int CLUSTER_COUNT_DEF = 512;

  localparam int MODE_W      = 2;
  localparam int CLUSTER_W   = 9;
  localparam int ENTRY_W     = 12;
  localparam int BYTE_ADDR_W = 10;
  localparam int BYTE_W      = 8;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd3;

  localparam logic [BYTE_W-1:0] HIGH_NIBBLE = 8'hF0;
  localparam logic [BYTE_W-1:0] LOW_NIBBLE  = 8'h0F;

  localparam int FIRST_CLUSTER = 2;

endpackage

FILE: rtl/fat12_table_engine.sv
// channel  dir  signals                           contents
// s_axis   in   tvalid tready tdata[39:0] tuser   one operation item
// m_axis   out  tvalid tready tdata[23:0]         one result item per operation
//
// load, read and write read the table in the accept cycle; the result and the
// write-back follow in the execute state once the output is free. find examines
// entries one after another, since each byte bank has a single read port.
// table bytes live in two banks (even and odd offsets) so an entry pair reads in one access.
// after reset a clearing pass zeroes the table; no item is taken meanwhile.
// a stalled result holds the block before write-back.
module fat12_table_engine
  import fte_pkg::*;
#(
  parameter int CLUSTER_COUNT = CLUSTER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cluster[8:0] entry_in[20:9] byte_address[30:21] byte_data[38:31] zero[39]
  input  logic [39:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entry_out[11:0] free_cluster[20:12] free_found[21] zero[23:22]
  output logic [23:0] m_axis_tdata
);

  localparam int CW   = $clog2(CLUSTER_COUNT);
  localparam int XW   = (CW > CLUSTER_W) ? CW : CLUSTER_W;
  localparam int OW0  = XW + 1;
  localparam int OW   = (OW0 > BYTE_ADDR_W) ? OW0 : BYTE_ADDR_W;
  localparam int TB   = (CLUSTER_COUNT * 3 + 1) / 2;
  localparam int EVN  = (TB + 1) / 2;
  localparam int ODN  = TB / 2;
  localparam int BAW  = $clog2(EVN);
  localparam int ODW  = $clog2(ODN);
  localparam int LAST = CLUSTER_COUNT - 1;
  localparam int SCAN_END = CLUSTER_COUNT - 2;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [1:0]             state;
  logic [BAW-1:0]         clr_cnt;

  logic                   accept;
  logic [MODE_W-1:0]      in_mode;
  logic [CLUSTER_W-1:0]   in_cluster;

  logic [MODE_W-1:0]      op_mode;
  logic [ENTRY_W-1:0]     op_entry;
  logic [BYTE_ADDR_W-1:0] op_baddr;
  logic [BYTE_W-1:0]      op_bdata;

  logic [XW-1:0]          rd_c;
  logic                   rd_re;
  logic [OW-1:0]          off;
  logic [OW-1:0]          off1;

  logic                   q_cl_odd;
  logic                   q_off_odd;
  logic                   q_lo_ok;
  logic                   q_hi_ok;
  logic [OW-2:0]          q_ev_a;
  logic [OW-2:0]          q_od_a;
  logic [CW-1:0]          chk_c;

  logic [BYTE_W-1:0]      ev_q;
  logic [BYTE_W-1:0]      od_q;
  logic [BYTE_W-1:0]      lo_b;
  logic [BYTE_W-1:0]      hi_b;
  logic [2*BYTE_W-1:0]    pair;
  logic [ENTRY_W-1:0]     entry_rd;
  logic [BYTE_W-1:0]      new_lo;
  logic [BYTE_W-1:0]      new_hi;

  logic                   ev_we;
  logic [OW-2:0]          ev_wa;
  logic [BYTE_W-1:0]      ev_wd;
  logic                   od_we;
  logic [OW-2:0]          od_wa;
  logic [BYTE_W-1:0]      od_wd;
  logic                   load_ok;

  logic                   out_free;
  logic                   exec_go;
  logic                   scan_hit;
  logic                   scan_stop;
  logic                   scan_go;
  logic [XW-1:0]          fc_wide;

  logic [ENTRY_W-1:0]     res_entry;
  logic [CLUSTER_W-1:0]   res_fc;
  logic                   res_found;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tuser;
  assign in_cluster    = s_axis_tdata[8:0];

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign exec_go   = (state == ST_EXEC) && out_free;
  assign scan_hit  = (entry_rd == '0);
  assign scan_stop = scan_hit || (chk_c == CW'(SCAN_END));
  assign scan_go   = (state == ST_SCAN) && scan_stop && out_free;

  // entry location for the read issued this cycle
  always_comb begin
    if (state == ST_SCAN) begin
      rd_c = XW'(CW'(chk_c + CW'(1)));
    end else if (in_mode == MODE_FIND) begin
      rd_c = XW'(FIRST_CLUSTER);
    end else begin
      rd_c = XW'(in_cluster);
    end
  end

  assign rd_re = accept || ((state == ST_SCAN) && !scan_stop);
  assign off   = OW'(rd_c) + OW'(rd_c >> 1);
  assign off1  = off + OW'(1);

  always_ff @(posedge clk) begin
    if (rd_re) begin
      q_cl_odd  <= rd_c[0];
      q_off_odd <= off[0];
      q_lo_ok   <= (off < OW'(TB));
      q_hi_ok   <= (off1 < OW'(TB));
      q_ev_a    <= off1[OW-1:1];
      q_od_a    <= off[OW-1:1];
      chk_c     <= rd_c[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= in_mode;
      op_entry <= s_axis_tdata[20:9];
      op_baddr <= s_axis_tdata[30:21];
      op_bdata <= s_axis_tdata[38:31];
    end
  end

  // pair assembly and entry extraction
  always_comb begin
    lo_b = '0;
    hi_b = '0;
    if (q_lo_ok) begin
      lo_b = q_off_odd ? od_q : ev_q;
    end
    if (q_hi_ok) begin
      hi_b = q_off_odd ? ev_q : od_q;
    end
    pair     = {hi_b, lo_b};
    entry_rd = q_cl_odd ? pair[15:4] : pair[11:0];
    if (q_cl_odd) begin
      new_lo = {op_entry[3:0], 4'd0} | (lo_b & LOW_NIBBLE);
      new_hi = op_entry[11:4];
    end else begin
      new_lo = op_entry[7:0];
      new_hi = (hi_b & HIGH_NIBBLE) | {4'd0, op_entry[11:8]};
    end
  end

  assign load_ok = (OW'(op_baddr) < OW'(TB));

  // bank write selection
  always_comb begin
    ev_we = 1'b0;
    od_we = 1'b0;
    ev_wa = q_ev_a;
    od_wa = q_od_a;
    ev_wd = '0;
    od_wd = '0;
    if (state == ST_CLR) begin
      ev_we = 1'b1;
      od_we = (32'(clr_cnt) < 32'(ODN));
      ev_wa = (OW-1)'(clr_cnt);
      od_wa = (OW-1)'(clr_cnt);
    end else if (exec_go && op_mode == MODE_LOAD) begin
      ev_wa = (OW-1)'(op_baddr[BYTE_ADDR_W-1:1]);
      od_wa = (OW-1)'(op_baddr[BYTE_ADDR_W-1:1]);
      ev_wd = op_bdata;
      od_wd = op_bdata;
      ev_we = load_ok && !op_baddr[0];
      od_we = load_ok && op_baddr[0];
    end else if (exec_go && op_mode == MODE_WRITE) begin
      if (q_off_odd) begin
        od_wd = new_lo;
        od_we = q_lo_ok;
        ev_wd = new_hi;
        ev_we = q_hi_ok;
      end else begin
        ev_wd = new_lo;
        ev_we = q_lo_ok;
        od_wd = new_hi;
        od_we = q_hi_ok;
      end
    end
  end

  fte_bank #(
    .DEPTH (EVN),
    .AW    (BAW)
  ) u_even (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_wa[BAW-1:0]),
    .wdata (ev_wd),
    .re    (rd_re),
    .raddr (off1[BAW:1]),
    .rdata (ev_q)
  );

  fte_bank #(
    .DEPTH (ODN),
    .AW    (ODW)
  ) u_odd (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_wa[ODW-1:0]),
    .wdata (od_wd),
    .re    (rd_re),
    .raddr (off[ODW:1]),
    .rdata (od_q)
  );

  assign fc_wide = scan_hit ? XW'(chk_c) : XW'(LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + BAW'(1);
          if (clr_cnt == BAW'(EVN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= (in_mode == MODE_FIND) ? ST_SCAN : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (exec_go || scan_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_entry <= (op_mode == MODE_READ) ? entry_rd : '0;
      res_fc    <= '0;
      res_found <= 1'b0;
    end else if (scan_go) begin
      res_entry <= '0;
      res_fc    <= fc_wide[CLUSTER_W-1:0];
      res_found <= scan_hit;
    end
  end

  assign m_axis_tdata = {2'd0, res_found, res_fc, res_entry};

endmodule

FILE: rtl/fte_bank.sv
module fte_bank
  import fte_pkg::*;
#(
  parameter int DEPTH = 384,
  parameter int AW    = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
